// ----- hw/rtl/uart_rf_pkg.sv -----
// Shared types, codes and constants for the four-port serial register file.
package uart_rf_pkg;

    localparam int MAX_PORTS      = 4;
    localparam int PORT_COUNT_DEF = 4;

    localparam logic [3:0] PORT_ENABLE_RST = 4'b0001;

    localparam logic [15:0] PORT_BASE [MAX_PORTS] = '{16'h03f8, 16'h02f8, 16'h03e8, 16'h02e8};

    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_RX    = 3'd2,
        REQ_CLAIM = 3'd3,
        REQ_CHECK = 3'd4
    } t_req;

    localparam logic [2:0] OFF_DATA = 3'd0;
    localparam logic [2:0] OFF_IER  = 3'd1;
    localparam logic [2:0] OFF_IIR  = 3'd2;
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;
    localparam logic [2:0] OFF_MSR  = 3'd6;
    localparam logic [2:0] OFF_SCR  = 3'd7;

    localparam logic [7:0] IIR_RX   = 8'h04;
    localparam logic [7:0] IIR_TX   = 8'h02;
    localparam logic [7:0] IIR_NONE = 8'h01;
    localparam logic [7:0] MSR_VAL  = 8'h80;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_CR  = 8'h0d;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       rx;
        logic       claim;
        logic [2:0] off;
        logic [7:0] wdata;
        logic [7:0] rxd;
    } t_port_cmd;

    typedef struct packed {
        logic may_irq;
        logic rdy;
        logic dlab;
    } t_port_stat;

endpackage

// ----- hw/rtl/uart_rf_port.sv -----
// Register set and status flags of one serial port.
module uart_rf_port (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  uart_rf_pkg::t_port_cmd i_cmd,
    output logic [7:0]             o_rd_data,
    output uart_rf_pkg::t_port_stat o_stat
);
    import uart_rf_pkg::*;

    logic [15:0] r_dl;
    logic [7:0]  r_ier;
    logic [7:0]  r_lcr;
    logic [7:0]  r_mcr;
    logic [7:0]  r_scr;
    logic [7:0]  r_rbr;
    logic r_dlab, r_out2, r_txen, r_rxen, r_thre, r_rdy;
    logic r_txbusy, r_rxnew, r_txint, r_rxint;

    assign o_stat.may_irq = r_out2 && ((r_txen && r_txbusy) || (r_rxen && r_rxnew));
    assign o_stat.rdy     = r_rdy;
    assign o_stat.dlab    = r_dlab;

    always_comb begin
        unique case (i_cmd.off)
            OFF_DATA: o_rd_data = r_dlab ? r_dl[7:0] : r_rbr;
            OFF_IER:  o_rd_data = r_dlab ? r_dl[15:8] : r_ier;
            OFF_IIR:  o_rd_data = r_rxint ? IIR_RX : (r_txint ? IIR_TX : IIR_NONE);
            OFF_LCR:  o_rd_data = r_lcr;
            OFF_MCR:  o_rd_data = r_mcr;
            OFF_LSR:  o_rd_data = {1'b0, 1'b1, r_thre, 4'b0000, r_rdy};
            OFF_MSR:  o_rd_data = MSR_VAL;
            OFF_SCR:  o_rd_data = r_scr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl     <= '0;
            r_ier    <= '0;
            r_lcr    <= '0;
            r_mcr    <= '0;
            r_scr    <= '0;
            r_rbr    <= '0;
            r_dlab   <= 1'b0;
            r_out2   <= 1'b0;
            r_txen   <= 1'b0;
            r_rxen   <= 1'b0;
            r_thre   <= 1'b1;
            r_rdy    <= 1'b0;
            r_txbusy <= 1'b0;
            r_rxnew  <= 1'b0;
            r_txint  <= 1'b0;
            r_rxint  <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                if (i_cmd.off == OFF_DATA && !r_dlab) begin
                    r_rdy   <= 1'b0;
                    r_rxint <= 1'b0;
                end
                if (i_cmd.off == OFF_IIR) begin
                    r_rxint <= 1'b0;
                    r_txint <= 1'b0;
                end
            end
            if (i_cmd.wr) begin
                unique case (i_cmd.off)
                    OFF_DATA: begin
                        if (r_dlab) begin
                            r_dl[7:0] <= i_cmd.wdata;
                        end else begin
                            r_txbusy <= 1'b1;
                            r_txint  <= 1'b0;
                        end
                    end
                    OFF_IER: begin
                        if (r_dlab) begin
                            r_dl[15:8] <= i_cmd.wdata;
                        end else begin
                            r_ier  <= i_cmd.wdata;
                            r_rxen <= i_cmd.wdata[0];
                            r_txen <= i_cmd.wdata[1];
                            if (!r_txen && i_cmd.wdata[1]) begin
                                r_txbusy <= 1'b1;
                            end
                        end
                    end
                    OFF_LCR: begin
                        r_lcr  <= i_cmd.wdata;
                        r_dlab <= i_cmd.wdata[7];
                    end
                    OFF_MCR: begin
                        r_mcr  <= i_cmd.wdata;
                        r_out2 <= i_cmd.wdata[3];
                    end
                    OFF_SCR: r_scr <= i_cmd.wdata;
                    OFF_IIR, OFF_LSR, OFF_MSR: ;
                endcase
            end
            if (i_cmd.rx) begin
                r_rbr   <= (i_cmd.rxd == CHAR_LF) ? CHAR_CR : i_cmd.rxd;
                r_rdy   <= 1'b1;
                r_rxnew <= 1'b1;
            end
            if (i_cmd.claim) begin
                if (r_txen && r_txbusy) begin
                    r_thre   <= 1'b1;
                    r_txint  <= 1'b1;
                    r_txbusy <= 1'b0;
                end else begin
                    r_rxint <= 1'b1;
                    r_rxnew <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/uart_register_file_four_ports.sv -----
// Top level of the four-port 16550-style serial register file.
// Each request word (read, write, received byte, interrupt claim, interrupt
// check) is decoded against COM1..COM4 at 3F8/2F8/3E8/2E8 and handled in the
// cycle it is accepted; its result word appears in the output register on the
// next edge. One word per cycle sustained while the result register is empty or being
// taken; a single decode/update step lies between the input handshake and the result
// register. A new word is accepted while the held result is being taken.
// port_enable is written through the config channel, always ready.
module uart_register_file_four_ports #(
    parameter int PORT_COUNT = uart_rf_pkg::PORT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_io_addr,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_rx_port,
    input  logic [7:0]  i_rx_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_irq_found,
    output logic [1:0]  o_irq_port,
    output logic        o_rx_accepted,
    output logic        o_addr_error
);
    import uart_rf_pkg::*;

    logic [3:0] r_port_enable;
    logic       r_out_valid;
    logic [7:0] r_read_data, r_tx_byte;
    logic       r_tx_valid, r_irq_found, r_rx_accepted, r_addr_error;
    logic [1:0] r_irq_port;

    logic [7:0] n_read_data, n_tx_byte;
    logic       n_tx_valid, n_irq_found, n_rx_accepted, n_addr_error;
    logic [1:0] n_irq_port;

    logic                 accept;
    logic                 is_rd, is_wr, is_rx, is_claim, is_irq;
    logic                 hit;
    logic [1:0]           hit_idx;
    logic [MAX_PORTS-1:0] port_on;
    logic [MAX_PORTS-1:0] irq_cand;
    logic [MAX_PORTS-1:0] claim_vec;
    logic                 claim_found;
    logic [1:0]           claim_idx;
    t_port_cmd            cmd   [MAX_PORTS];
    t_port_stat           stat  [MAX_PORTS];
    logic [7:0]           rdata [MAX_PORTS];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    assign is_rd    = (i_req_type == REQ_READ);
    assign is_wr    = (i_req_type == REQ_WRITE);
    assign is_rx    = (i_req_type == REQ_RX);
    assign is_claim = (i_req_type == REQ_CLAIM);
    assign is_irq   = is_claim || (i_req_type == REQ_CHECK);

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = 0; k < MAX_PORTS; k++) begin
            if (i_io_addr[15:3] == PORT_BASE[k][15:3]) begin
                hit     = 1'b1;
                hit_idx = 2'(k);
            end
        end
    end

    always_comb begin
        claim_found = 1'b0;
        claim_idx   = '0;
        for (int k = MAX_PORTS - 1; k >= 0; k--) begin
            if (irq_cand[k]) begin
                claim_found = 1'b1;
                claim_idx   = 2'(k);
            end
        end
    end

    for (genvar g = 0; g < MAX_PORTS; g++) begin : g_port
        assign port_on[g]   = (g < PORT_COUNT) && r_port_enable[g];
        assign irq_cand[g]  = port_on[g] && stat[g].may_irq;
        assign claim_vec[g] = cmd[g].claim;

        assign cmd[g].rd    = accept && is_rd && hit && hit_idx == 2'(g) && port_on[g];
        assign cmd[g].wr    = accept && is_wr && hit && hit_idx == 2'(g) && port_on[g];
        assign cmd[g].rx    = accept && is_rx && i_rx_port == 2'(g) && port_on[g]
                              && !stat[g].rdy;
        assign cmd[g].claim = accept && is_claim && claim_found && claim_idx == 2'(g);
        assign cmd[g].off   = i_io_addr[2:0];
        assign cmd[g].wdata = i_write_data;
        assign cmd[g].rxd   = i_rx_data;

        if (g < PORT_COUNT) begin : g_on
            uart_rf_port u_port (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (cmd[g]),
                .o_rd_data (rdata[g]),
                .o_stat    (stat[g])
            );
        end else begin : g_off
            assign rdata[g] = '0;
            assign stat[g]  = '0;
        end
    end

    always_comb begin
        n_read_data   = '0;
        n_tx_valid    = 1'b0;
        n_tx_byte     = '0;
        n_irq_found   = 1'b0;
        n_irq_port    = '0;
        n_rx_accepted = 1'b0;
        n_addr_error  = 1'b0;
        if (is_rd || is_wr) begin
            if (!hit) begin
                n_addr_error = 1'b1;
            end else if (port_on[hit_idx]) begin
                if (is_rd) begin
                    n_read_data = rdata[hit_idx];
                end else if (i_io_addr[2:0] == OFF_DATA && !stat[hit_idx].dlab) begin
                    n_tx_valid = 1'b1;
                    n_tx_byte  = i_write_data;
                end
            end
        end else if (is_rx) begin
            n_rx_accepted = port_on[i_rx_port] && !stat[i_rx_port].rdy;
        end else if (is_irq) begin
            n_irq_found = claim_found;
            n_irq_port  = claim_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_enable <= PORT_ENABLE_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_port_enable <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data   <= n_read_data;
            r_tx_valid    <= n_tx_valid;
            r_tx_byte     <= n_tx_byte;
            r_irq_found   <= n_irq_found;
            r_irq_port    <= n_irq_port;
            r_rx_accepted <= n_rx_accepted;
            r_addr_error  <= n_addr_error;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_irq_found   = r_irq_found;
    assign o_irq_port    = r_irq_port;
    assign o_rx_accepted = r_rx_accepted;
    assign o_addr_error  = r_addr_error;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && !i_out_ready && accept))
        else $error("result word overwritten while stalled");

    a_one_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(claim_vec))
        else $error("more than one port claimed");

    a_tx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_tx_valid && (r_addr_error || r_irq_found || r_rx_accepted)))
        else $error("tx result mixed with other results");

    a_rx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rx_accepted) |-> (r_read_data == 8'h00 && !r_irq_found
                                            && !r_addr_error))
        else $error("rx result carries other fields");

endmodule

// ----- dv/uart_register_file_four_ports_checker.sv -----
// Checker for the four-port serial register file: predicts every response word and compares it.
`timescale 1ns / 1ps

module uart_register_file_four_ports_checker #(
    parameter int PORT_COUNT = uart_rf_pkg::PORT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_io_addr,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_rx_port,
    input  logic [7:0]  i_rx_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [7:0]  i_read_data,
    input  logic        i_tx_valid,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_irq_found,
    input  logic [1:0]  i_irq_port,
    input  logic        i_rx_accepted,
    input  logic        i_addr_error,
    output int          o_errors,
    output int          o_pending
);

    import uart_rf_pkg::*;

    localparam int FL_DLAB   = 0;
    localparam int FL_OUT2   = 1;
    localparam int FL_TXEN   = 2;
    localparam int FL_RXEN   = 3;
    localparam int FL_THRE   = 4;
    localparam int FL_RDY    = 5;
    localparam int FL_TXBUSY = 6;
    localparam int FL_RXNEW  = 7;
    localparam int FL_TXINT  = 8;
    localparam int FL_RXINT  = 9;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_found;
        logic [1:0] irq_port;
        logic       rx_accepted;
        logic       addr_error;
    } t_reply;

    logic [3:0]  port_enable;
    logic [15:0] divisor [MAX_PORTS];
    logic [7:0]  ier_q   [MAX_PORTS];
    logic [7:0]  lcr_q   [MAX_PORTS];
    logic [7:0]  mcr_q   [MAX_PORTS];
    logic [7:0]  scr_q   [MAX_PORTS];
    logic [7:0]  rbr_q   [MAX_PORTS];
    logic [9:0]  flags   [MAX_PORTS];
    t_reply      replies_owed [$];
    int          mismatch_count = 0;

    function automatic void reset_state();
        int i;
        port_enable = PORT_ENABLE_RST;
        for (i = 0; i < MAX_PORTS; i++) begin
            divisor[i] = '0;
            ier_q[i]   = '0;
            lcr_q[i]   = '0;
            mcr_q[i]   = '0;
            scr_q[i]   = '0;
            rbr_q[i]   = '0;
            flags[i]   = '0;
            flags[i][FL_THRE] = 1'b1;
        end
    endfunction

    function automatic logic port_on(input int p);
        return (p < PORT_COUNT) && port_enable[p];
    endfunction

    function automatic logic may_irq(input int p);
        logic [9:0] f;
        f = flags[p];
        return f[FL_OUT2] && ((f[FL_TXEN] && f[FL_TXBUSY]) || (f[FL_RXEN] && f[FL_RXNEW]));
    endfunction

    function automatic int find_port(input logic [15:0] addr, output logic [2:0] off);
        int i;
        off = '0;
        for (i = 0; i < MAX_PORTS; i++) begin
            if ({1'b0, addr} >= {1'b0, PORT_BASE[i]} &&
                {1'b0, addr} < {1'b0, PORT_BASE[i]} + 17'd8) begin
                off = 3'(addr - PORT_BASE[i]);
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [7:0] read_register(input int p, input logic [2:0] off);
        logic [7:0] v;
        v = '0;
        case (off)
            OFF_DATA: begin
                if (flags[p][FL_DLAB]) begin
                    v = divisor[p][7:0];
                end else begin
                    flags[p][FL_RDY]   = 1'b0;
                    flags[p][FL_RXINT] = 1'b0;
                    v = rbr_q[p];
                end
            end
            OFF_IER: v = flags[p][FL_DLAB] ? divisor[p][15:8] : ier_q[p];
            OFF_IIR: begin
                if (flags[p][FL_RXINT]) v = IIR_RX;
                else if (flags[p][FL_TXINT]) v = IIR_TX;
                else v = IIR_NONE;
                flags[p][FL_RXINT] = 1'b0;
                flags[p][FL_TXINT] = 1'b0;
            end
            OFF_LCR: v = lcr_q[p];
            OFF_MCR: v = mcr_q[p];
            OFF_LSR: v = {1'b0, 1'b1, flags[p][FL_THRE], 4'b0000, flags[p][FL_RDY]};
            OFF_MSR: v = MSR_VAL;
            default: v = scr_q[p];
        endcase
        return v;
    endfunction

    function automatic t_reply serve_request(input logic [2:0] req, input logic [15:0] addr,
                                             input logic [7:0] wdata, input logic [1:0] rxp,
                                             input logic [7:0] rxd);
        t_reply     r;
        int         p;
        int         i;
        logic [2:0] off;
        logic       was_tx;
        r = '0;
        case (req)
            REQ_READ, REQ_WRITE: begin
                p = find_port(addr, off);
                if (p < 0) begin
                    r.addr_error = 1'b1;
                end else if (port_on(p)) begin
                    if (req == REQ_READ) begin
                        r.read_data = read_register(p, off);
                    end else begin
                        case (off)
                            OFF_DATA: begin
                                if (flags[p][FL_DLAB]) begin
                                    divisor[p][7:0] = wdata;
                                end else begin
                                    flags[p][FL_TXBUSY] = 1'b1;
                                    flags[p][FL_TXINT]  = 1'b0;
                                    r.tx_valid = 1'b1;
                                    r.tx_byte  = wdata;
                                end
                            end
                            OFF_IER: begin
                                if (flags[p][FL_DLAB]) begin
                                    divisor[p][15:8] = wdata;
                                end else begin
                                    was_tx = flags[p][FL_TXEN];
                                    ier_q[p] = wdata;
                                    flags[p][FL_RXEN] = wdata[0];
                                    flags[p][FL_TXEN] = wdata[1];
                                    if (!was_tx && wdata[1]) flags[p][FL_TXBUSY] = 1'b1;
                                end
                            end
                            OFF_LCR: begin
                                lcr_q[p] = wdata;
                                flags[p][FL_DLAB] = wdata[7];
                            end
                            OFF_MCR: begin
                                mcr_q[p] = wdata;
                                flags[p][FL_OUT2] = wdata[3];
                            end
                            OFF_SCR: scr_q[p] = wdata;
                            // FCR, LSR and MSR writes leave nothing visible
                            default: ;
                        endcase
                    end
                end
            end
            REQ_RX: begin
                if (port_on(rxp) && !flags[rxp][FL_RDY]) begin
                    rbr_q[rxp] = (rxd == CHAR_LF) ? CHAR_CR : rxd;
                    flags[rxp][FL_RDY]   = 1'b1;
                    flags[rxp][FL_RXNEW] = 1'b1;
                    r.rx_accepted = 1'b1;
                end
            end
            REQ_CLAIM, REQ_CHECK: begin
                for (i = 0; i < MAX_PORTS; i++) begin
                    if (!r.irq_found && port_on(i) && may_irq(i)) begin
                        if (req == REQ_CLAIM) begin
                            if (flags[i][FL_TXEN] && flags[i][FL_TXBUSY]) begin
                                flags[i][FL_THRE]   = 1'b1;
                                flags[i][FL_TXINT]  = 1'b1;
                                flags[i][FL_TXBUSY] = 1'b0;
                            end else begin
                                flags[i][FL_RXINT] = 1'b1;
                                flags[i][FL_RXNEW] = 1'b0;
                            end
                        end
                        r.irq_found = 1'b1;
                        r.irq_port  = 2'(i);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            reset_state();
            replies_owed.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got.read_data   = i_read_data;
                got.tx_valid    = i_tx_valid;
                got.tx_byte     = i_tx_byte;
                got.irq_found   = i_irq_found;
                got.irq_port    = i_irq_port;
                got.rx_accepted = i_rx_accepted;
                got.addr_error  = i_addr_error;
                if (replies_owed.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: response word expected none got %0h", $time, got);
                end else begin
                    want = replies_owed.pop_front();
                    compare_field("read_data", want.read_data, got.read_data);
                    compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                    compare_field("tx_byte", want.tx_byte, got.tx_byte);
                    compare_field("irq_found", 8'(want.irq_found), 8'(got.irq_found));
                    compare_field("irq_port", 8'(want.irq_port), 8'(got.irq_port));
                    compare_field("rx_accepted", 8'(want.rx_accepted), 8'(got.rx_accepted));
                    compare_field("addr_error", 8'(want.addr_error), 8'(got.addr_error));
                end
            end
            if (i_cfg_valid && i_cfg_ready) port_enable = i_cfg_data;
            if (i_req_valid && i_req_ready) begin
                replies_owed.push_back(serve_request(i_req_type, i_io_addr, i_write_data,
                                                     i_rx_port, i_rx_data));
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= replies_owed.size();
    end

endmodule

// ----- dv/uart_register_file_four_ports_test.sv -----
// Testbench top for the four-port serial register file: stimulus, idle profiles and verdict.
`timescale 1ns / 1ps

module uart_register_file_four_ports_test;

    import uart_rf_pkg::*;

    localparam int PORTS        = PORT_COUNT_DEF;
    localparam int RST_CYCLES   = 7;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_WORDS = 1160;
    localparam int SEGMENTS     = 8;
    localparam int TAIL_CYCLES  = 4;

    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [1:0]  rxp;
        logic [7:0]  rxd;
    } t_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data   = PORT_ENABLE_RST;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type   = REQ_READ;
    logic [15:0] i_io_addr    = '0;
    logic [7:0]  i_write_data = '0;
    logic [1:0]  i_rx_port    = '0;
    logic [7:0]  i_rx_data    = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_irq_found;
    logic [1:0]  o_irq_port;
    logic        o_rx_accepted;
    logic        o_addr_error;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet          = 0;
    int words_sent     = 0;
    int cfg_writes     = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    uart_register_file_four_ports #(
        .PORT_COUNT(PORTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_io_addr    (i_io_addr),
        .i_write_data (i_write_data),
        .i_rx_port    (i_rx_port),
        .i_rx_data    (i_rx_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_irq_found  (o_irq_found),
        .o_irq_port   (o_irq_port),
        .o_rx_accepted(o_rx_accepted),
        .o_addr_error (o_addr_error)
    );

    uart_register_file_four_ports_checker #(
        .PORT_COUNT(PORTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (i_in_valid),
        .i_req_ready  (o_in_ready),
        .i_req_type   (i_req_type),
        .i_io_addr    (i_io_addr),
        .i_write_data (i_write_data),
        .i_rx_port    (i_rx_port),
        .i_rx_data    (i_rx_data),
        .i_rsp_valid  (o_out_valid),
        .i_rsp_ready  (i_out_ready),
        .i_read_data  (o_read_data),
        .i_tx_valid   (o_tx_valid),
        .i_tx_byte    (o_tx_byte),
        .i_irq_found  (o_irq_found),
        .i_irq_port   (o_irq_port),
        .i_rx_accepted(o_rx_accepted),
        .i_addr_error (o_addr_error),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_word noise_word();
        t_word w;
        w.req   = 3'($urandom_range(7));
        w.addr  = 16'($urandom_range(16'hffff));
        w.wdata = 8'($urandom_range(255));
        w.rxp   = 2'($urandom_range(3));
        w.rxd   = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic t_word reg_word(input logic [2:0] req, input int p,
                                       input logic [2:0] off, input logic [7:0] d);
        t_word w;
        w = noise_word();
        w.req   = req;
        w.addr  = PORT_BASE[p] + 16'(off);
        w.wdata = d;
        return w;
    endfunction

    function automatic t_word rx_word(input int p, input logic [7:0] d);
        t_word w;
        w = noise_word();
        w.req = REQ_RX;
        w.rxp = 2'(p);
        w.rxd = d;
        return w;
    endfunction

    function automatic t_word addr_word(input logic [2:0] req, input logic [15:0] a,
                                        input logic [7:0] d);
        t_word w;
        w = noise_word();
        w.req   = req;
        w.addr  = a;
        w.wdata = d;
        return w;
    endfunction

    function automatic t_word bare_word(input logic [2:0] req);
        t_word w;
        w = noise_word();
        w.req = req;
        return w;
    endfunction

    function automatic t_word pick_request();
        t_word      w;
        int         roll;
        int         p;
        logic [2:0] off;
        logic [7:0] d;
        roll = $urandom_range(99);
        p    = $urandom_range(MAX_PORTS - 1);
        off  = 3'($urandom_range(7));
        d    = 8'($urandom_range(255));
        if (roll < 55) begin
            if (off == OFF_LCR) d[7] = 1'($urandom_range(1));
            if (off == OFF_MCR) d[3] = ($urandom_range(9) != 0);
            w = reg_word($urandom_range(1) ? REQ_WRITE : REQ_READ, p, off, d);
        end else if (roll < 70) begin
            w = rx_word(p, ($urandom_range(4) == 0) ? CHAR_LF : d);
        end else if (roll < 85) begin
            w = bare_word($urandom_range(1) ? REQ_CLAIM : REQ_CHECK);
        end else if (roll < 93) begin
            w = noise_word();
            w.req = $urandom_range(1) ? REQ_WRITE : REQ_READ;
            // just outside a port window
            if ($urandom_range(1)) begin
                w.addr = $urandom_range(1) ? PORT_BASE[p] - 16'd1 : PORT_BASE[p] + 16'd8;
            end
        end else begin
            w = noise_word();
            w.req = 3'($urandom_range(7, 5));
        end
        return w;
    endfunction

    task automatic send_word(input t_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= w.req;
        i_io_addr    <= w.addr;
        i_write_data <= w.wdata;
        i_rx_port    <= w.rxp;
        i_rx_data    <= w.rxd;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic [3:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // divisor, line format, OUT2 and interrupt enables for one port
    task automatic bring_up(input int p);
        logic [7:0] d;
        d = 8'($urandom_range(255));
        d[7] = 1'b1;
        send_word(reg_word(REQ_WRITE, p, OFF_LCR, d));
        send_word(reg_word(REQ_WRITE, p, OFF_DATA, 8'($urandom_range(255))));
        send_word(reg_word(REQ_WRITE, p, OFF_IER, 8'($urandom_range(255))));
        d = 8'($urandom_range(255));
        d[7] = 1'b0;
        send_word(reg_word(REQ_WRITE, p, OFF_LCR, d));
        d = 8'($urandom_range(255));
        d[3] = 1'b1;
        send_word(reg_word(REQ_WRITE, p, OFF_MCR, d));
        send_word(reg_word(REQ_WRITE, p, OFF_IER, 8'($urandom_range(255))));
    endtask

    initial begin
        logic [3:0] enable;
        int         seg;
        int         n;
        int         p;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // only COM1 enabled out of reset
        send_word(reg_word(REQ_READ, 0, OFF_LSR, 8'h00));
        send_word(reg_word(REQ_READ, 0, OFF_MSR, 8'h00));
        send_word(reg_word(REQ_WRITE, 1, OFF_SCR, 8'hff));
        send_word(reg_word(REQ_READ, 1, OFF_SCR, 8'h00));
        send_word(rx_word(1, 8'h41));
        send_word(addr_word(REQ_READ, 16'h0000, 8'h00));
        send_word(addr_word(REQ_WRITE, 16'hffff, 8'hff));
        send_word('{req: 3'd7, addr: 16'hffff, wdata: 8'hff, rxp: 2'd3, rxd: 8'hff});

        write_enable(4'hf);
        send_word(reg_word(REQ_WRITE, 0, OFF_LCR, 8'h80));
        send_word(reg_word(REQ_WRITE, 0, OFF_DATA, 8'hff));
        send_word(reg_word(REQ_WRITE, 0, OFF_IER, 8'h00));
        send_word(reg_word(REQ_READ, 0, OFF_DATA, 8'h00));
        send_word(reg_word(REQ_READ, 0, OFF_IER, 8'h00));
        send_word(reg_word(REQ_WRITE, 0, OFF_LCR, 8'h03));
        send_word(reg_word(REQ_WRITE, 0, OFF_MCR, 8'h08));
        send_word(reg_word(REQ_WRITE, 0, OFF_IER, 8'h03));
        send_word(bare_word(REQ_CHECK));
        send_word(bare_word(REQ_CLAIM));
        send_word(reg_word(REQ_READ, 0, OFF_IIR, 8'h00));
        send_word(rx_word(0, CHAR_LF));
        send_word(rx_word(0, 8'hff));
        send_word(bare_word(REQ_CLAIM));
        send_word(reg_word(REQ_READ, 0, OFF_IIR, 8'h00));
        send_word(reg_word(REQ_READ, 0, OFF_DATA, 8'h00));
        send_word(reg_word(REQ_WRITE, 0, OFF_DATA, 8'h00));
        send_word(reg_word(REQ_WRITE, 0, OFF_LSR, 8'hff));
        send_word(reg_word(REQ_WRITE, 3, OFF_SCR, 8'ha5));
        send_word(reg_word(REQ_READ, 3, OFF_SCR, 8'h00));
        send_word(addr_word(REQ_READ, 16'h0400, 8'h00));

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0, 4, 7: enable = 4'hf;
                1:       enable = 4'h0;
                2:       enable = 4'h9;
                5:       enable = 4'h6;
                default: enable = 4'($urandom_range(15));
            endcase
            write_enable(enable);
            case (seg % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            for (p = 0; p < MAX_PORTS; p++) bring_up(p);
            for (n = 0; n < RANDOM_WORDS / SEGMENTS; n++) begin
                if ($urandom_range(49) == 0) bring_up($urandom_range(MAX_PORTS - 1));
                else send_word(pick_request());
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
        $display("covered %0d request words over %0d port-enable writes and four idle profiles",
                 words_sent, cfg_writes);
        $display("failed checks %0d, responses still owed %0d", errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
